// File: design/sgdlf_pkg.sv
package sgdlf_pkg;

  // Fixed widths of the request and result fields
  localparam int VALUE_W   = 32;
  localparam int FRAC_BITS = 24;
  localparam int NODE_W    = 12;
  localparam int ELEM_IN_W = 5;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_REG_W = 31;

  // Defaults for the top-level parameters
  localparam int DEF_VECTOR_LEN = 20;
  localparam int DEF_NODE_COUNT = 4096;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGULARIZATION = 2'd1;

  localparam logic [CFG_REG_W-1:0] STEP_SIZE_RESET      = 31'd1677722;
  localparam logic [CFG_REG_W-1:0] REGULARIZATION_RESET = 31'd838861;

  typedef logic signed [VALUE_W-1:0] val_t;

  typedef struct packed {
    val_t val;
    logic sat;
  } sat_val_t;

  localparam int PROD_W = 2 * VALUE_W;
  localparam int Q_W    = PROD_W - FRAC_BITS;

  localparam val_t VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  // Saturating add
  function automatic sat_val_t sat_add(input val_t a, input val_t b);
    logic [VALUE_W:0] s;
    sat_val_t r;
    s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
    if (s[VALUE_W] != s[VALUE_W-1]) begin
      r.sat = 1'b1;
      r.val = s[VALUE_W] ? VAL_MIN : VAL_MAX;
    end else begin
      r.sat = 1'b0;
      r.val = s[VALUE_W-1:0];
    end
    return r;
  endfunction

  // Saturating subtract
  function automatic sat_val_t sat_sub(input val_t a, input val_t b);
    logic [VALUE_W:0] s;
    sat_val_t r;
    s = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
    if (s[VALUE_W] != s[VALUE_W-1]) begin
      r.sat = 1'b1;
      r.val = s[VALUE_W] ? VAL_MIN : VAL_MAX;
    end else begin
      r.sat = 1'b0;
      r.val = s[VALUE_W-1:0];
    end
    return r;
  endfunction

  // Fixed-point multiply: exact product, round half up at the binary point, clamp
  function automatic sat_val_t mul_q(input val_t a, input val_t b);
    logic signed [PROD_W-1:0] p;
    logic [Q_W-1:0] q;
    sat_val_t r;
    p = a * b;
    p = p + ROUND_HALF;
    q = p[PROD_W-1:FRAC_BITS];
    if ((&q[Q_W-1:VALUE_W-1]) || !(|q[Q_W-1:VALUE_W-1])) begin
      r.sat = 1'b0;
      r.val = q[VALUE_W-1:0];
    end else begin
      r.sat = 1'b1;
      r.val = q[Q_W-1] ? VAL_MIN : VAL_MAX;
    end
    return r;
  endfunction

endpackage

// File: design/sgdlf_store.sv
module sgdlf_store
  import sgdlf_pkg::*;
#(
  parameter int DEPTH  = DEF_NODE_COUNT * DEF_VECTOR_LEN,
  parameter int ADDR_W = $clog2(DEF_NODE_COUNT * DEF_VECTOR_LEN)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  val_t              wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output val_t              rdata_a,
  output val_t              rdata_b
);

  logic [VALUE_W-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read two entries, registered
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: design/sgd_latent_factor_update_core.sv
// Latent-factor SGD update engine. A request is taken when start is high and busy is low;
// its single result appears on out_result_value/out_saturated for exactly one cycle with
// out_valid high, and the receiver cannot stall it. The update time is set by the latent
// store: the dot product streams VECTOR_LEN element pairs through its two read ports, then
// the update writes the item and the user element of each position through the single
// write port, one per cycle, behind a four-stage multiply pipeline. The store is not
// cleared by reset; an element must be loaded before it is read or updated. Configuration
// writes are always ready and belong between requests.
module sgd_latent_factor_update_core
  import sgdlf_pkg::*;
#(
  parameter int VECTOR_LEN = DEF_VECTOR_LEN,
  parameter int NODE_COUNT = DEF_NODE_COUNT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [NODE_W-1:0]    in_item_node,
  input  logic [NODE_W-1:0]    in_user_node,
  input  logic [ELEM_IN_W-1:0] in_element_index,
  input  val_t                 in_value,
  output logic                 out_valid,
  output val_t                 out_result_value,
  output logic                 out_saturated,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_REG_W-1:0] cfg_data
);

  localparam int DEPTH  = NODE_COUNT * VECTOR_LEN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ELEM_W = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
  localparam int CNT_W  = $clog2(2 * VECTOR_LEN);
  localparam int FULL_W = ADDR_W + NODE_W;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_EXEC     = 3'd1;
  localparam logic [2:0] ST_READ     = 3'd2;
  localparam logic [2:0] ST_DOT      = 3'd3;
  localparam logic [2:0] ST_DOT_WAIT = 3'd4;
  localparam logic [2:0] ST_UPD      = 3'd5;
  localparam logic [2:0] ST_UPD_WAIT = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_vld_r, out_vld_nxt;
  val_t                 out_val_r, out_val_nxt;
  logic                 out_sat_r, out_sat_nxt;

  logic [CFG_REG_W-1:0] step_r, lam_r;

  // Latched request
  logic [MODE_W-1:0]    mode_r;
  logic                 req_ok_r;
  logic                 same_node_r;
  logic [ELEM_IN_W-1:0] elem_r;
  val_t                 value_r;
  logic [ADDR_W-1:0]    item_base_r, user_base_r;
  logic [FULL_W-1:0]    item_base_full, user_base_full;
  logic                 item_ok, user_ok, elem_ok, req_ok;

  // Arithmetic state
  val_t                 acc_r, err_r, partial_r;
  logic                 flag_r;

  // Pipeline
  logic                 s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic                 s1_side_r, s2_side_r, s3_side_r, s4_side_r;
  logic [ELEM_W-1:0]    s1_elem_r, s2_elem_r, s3_elem_r, s4_elem_r;
  val_t                 s2_self_r, s3_self_r, s4_self_r;
  val_t                 pa_r, pb_r, d_r, inc_r;

  // Memory interface
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr, rd_addr_a, rd_addr_b;
  val_t                 mem_wdata, rd_a, rd_b;

  logic [ELEM_W-1:0]    elem_sel;
  logic                 issue_vld, upd_phase, pipe_empty, err_load;
  val_t                 op_a1, op_a2, self_s1, s4_base;
  sat_val_t             mul_a, mul_b, mul_c, acc_sum, diff, s4_sum, err_diff;

  assign busy             = (state_r != ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_vld_r;
  assign out_result_value = out_val_r;
  assign out_saturated    = out_sat_r;

  // Decode the incoming request
  always_comb begin
    item_base_full = FULL_W'(in_item_node) * FULL_W'(VECTOR_LEN);
    user_base_full = FULL_W'(in_user_node) * FULL_W'(VECTOR_LEN);
    item_ok = 32'(in_item_node) < 32'(NODE_COUNT);
    user_ok = 32'(in_user_node) < 32'(NODE_COUNT);
    elem_ok = 32'(in_element_index) < 32'(VECTOR_LEN);
    case (in_mode)
      MODE_LOAD, MODE_READ: req_ok = item_ok && elem_ok;
      MODE_UPDATE:          req_ok = item_ok && user_ok;
      default:              req_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!busy && start) begin
      mode_r      <= in_mode;
      req_ok_r    <= req_ok;
      same_node_r <= (in_item_node == in_user_node);
      elem_r      <= in_element_index;
      value_r     <= in_value;
      item_base_r <= item_base_full[ADDR_W-1:0];
      user_base_r <= user_base_full[ADDR_W-1:0];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_SIZE_RESET;
      lam_r  <= REGULARIZATION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_SIZE:      step_r <= cfg_data;
        REG_REGULARIZATION: lam_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Address generation and write-port arbitration
  always_comb begin
    upd_phase  = (state_r == ST_UPD) || (state_r == ST_UPD_WAIT);
    issue_vld  = (state_r == ST_DOT) || (state_r == ST_UPD);
    pipe_empty = !s1_vld_r && !s2_vld_r && !s3_vld_r && !s4_vld_r;
    elem_sel   = (state_r == ST_UPD) ? ELEM_W'(cnt_r >> 1) : ELEM_W'(cnt_r);
    if (state_r == ST_EXEC) begin
      rd_addr_a = item_base_r + ADDR_W'(elem_r);
    end else begin
      rd_addr_a = item_base_r + ADDR_W'(elem_sel);
    end
    rd_addr_b = user_base_r + ADDR_W'(elem_sel);

    s4_base = (s4_side_r && same_node_r) ? partial_r : s4_self_r;
    s4_sum  = sat_add(s4_base, inc_r);

    mem_we    = 1'b0;
    mem_waddr = item_base_r + ADDR_W'(elem_r);
    mem_wdata = value_r;
    if (s4_vld_r) begin
      // drop the item-side write when both nodes share one vector
      mem_we    = s4_side_r || !same_node_r;
      mem_waddr = (s4_side_r ? user_base_r : item_base_r) + ADDR_W'(s4_elem_r);
      mem_wdata = s4_sum.val;
    end else if (state_r == ST_EXEC && mode_r == MODE_LOAD && req_ok_r) begin
      mem_we = 1'b1;
    end
  end

  sgdlf_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Shared multipliers and adders
  always_comb begin
    // dot: item*user; update item side: err*user, user side: err*item
    op_a1    = upd_phase ? err_r : rd_a;
    op_a2    = (upd_phase && s1_side_r) ? rd_a : rd_b;
    self_s1  = s1_side_r ? rd_b : rd_a;
    mul_a    = mul_q(op_a1, op_a2);
    mul_b    = mul_q({1'b0, lam_r}, self_s1);
    acc_sum  = sat_add(acc_r, pa_r);
    diff     = sat_sub(pa_r, pb_r);
    mul_c    = mul_q({1'b0, step_r}, d_r);
    err_load = (state_r == ST_DOT_WAIT) && pipe_empty;
    err_diff = sat_sub(value_r, acc_r);
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r && upd_phase;
      s4_vld_r <= s3_vld_r;
    end
  end

  // Pipeline data, accumulator and sticky saturation flag
  always_ff @(posedge clk) begin
    s1_side_r <= cnt_r[0];
    s1_elem_r <= elem_sel;

    s2_side_r <= s1_side_r;
    s2_elem_r <= s1_elem_r;
    s2_self_r <= self_s1;
    pa_r      <= mul_a.val;
    pb_r      <= mul_b.val;

    s3_side_r <= s2_side_r;
    s3_elem_r <= s2_elem_r;
    s3_self_r <= s2_self_r;
    d_r       <= diff.val;

    s4_side_r <= s3_side_r;
    s4_elem_r <= s3_elem_r;
    s4_self_r <= s3_self_r;
    inc_r     <= mul_c.val;

    // hold the item-side sum for the shared-vector case
    if (s4_vld_r && !s4_side_r) begin
      partial_r <= s4_sum.val;
    end

    if (state_r == ST_EXEC) begin
      acc_r  <= '0;
      flag_r <= 1'b0;
    end else begin
      if (s2_vld_r && !upd_phase) begin
        acc_r <= acc_sum.val;
      end
      flag_r <= flag_r
              | (s1_vld_r && (mul_a.sat || (upd_phase && mul_b.sat)))
              | (s2_vld_r && (upd_phase ? diff.sat : acc_sum.sat))
              | (s3_vld_r && mul_c.sat)
              | (s4_vld_r && s4_sum.sat)
              | (err_load && err_diff.sat);
    end
    if (err_load) begin
      err_r <= err_diff.val;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    out_vld_nxt = 1'b0;
    out_val_nxt = out_val_r;
    out_sat_nxt = out_sat_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cnt_nxt     = '0;
        out_val_nxt = '0;
        out_sat_nxt = 1'b0;
        state_nxt   = ST_IDLE;
        case (mode_r)
          MODE_LOAD: begin
            out_vld_nxt = 1'b1;
            out_val_nxt = req_ok_r ? value_r : '0;
          end
          MODE_READ: begin
            if (req_ok_r) begin
              state_nxt = ST_READ;
            end else begin
              out_vld_nxt = 1'b1;
            end
          end
          MODE_UPDATE: begin
            if (req_ok_r) begin
              state_nxt = ST_DOT;
            end else begin
              out_vld_nxt = 1'b1;
            end
          end
          default: begin
            out_vld_nxt = 1'b1;
          end
        endcase
      end
      ST_READ: begin
        out_vld_nxt = 1'b1;
        out_val_nxt = rd_a;
        out_sat_nxt = 1'b0;
        state_nxt   = ST_IDLE;
      end
      ST_DOT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VECTOR_LEN - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DOT_WAIT;
        end
      end
      ST_DOT_WAIT: begin
        if (pipe_empty) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(2 * VECTOR_LEN - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_UPD_WAIT;
        end
      end
      ST_UPD_WAIT: begin
        if (pipe_empty) begin
          out_vld_nxt = 1'b1;
          out_val_nxt = err_r;
          out_sat_nxt = flag_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_val_r <= out_val_nxt;
    out_sat_r <= out_sat_nxt;
  end

endmodule

// File: test/sgd_latent_factor_update_core_tb.sv
`timescale 1ns / 1ps

module sgd_latent_factor_update_core_tb;
  import sgdlf_pkg::*;

  localparam int VLEN      = DEF_VECTOR_LEN;
  localparam int NODES     = DEF_NODE_COUNT;
  localparam int NODE_LAST = NODES - 1;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int PHASES    = 5;
  localparam int MIX_ITEMS = 60;
  localparam int CALM_TAIL = 40;

  localparam logic [MODE_W-1:0]    MODE_NOP  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [CFG_REG_W-1:0] CFG_MAX   = {CFG_REG_W{1'b1}};

  localparam longint VMAX = (64'sd1 <<< (VALUE_W - 1)) - 1;
  localparam longint VMIN = -(64'sd1 <<< (VALUE_W - 1));

  // One queued entry: either a request or a register write
  typedef struct packed {
    logic                 is_cfg;
    logic [MODE_W-1:0]    mode;
    logic [NODE_W-1:0]    item_node;
    logic [NODE_W-1:0]    user_node;
    logic [ELEM_IN_W-1:0] elem;
    val_t                 value;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_REG_W-1:0] reg_data;
  } pending_op_t;

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 start            = 1'b0;
  logic                 busy;
  logic [MODE_W-1:0]    in_mode          = '0;
  logic [NODE_W-1:0]    in_item_node     = '0;
  logic [NODE_W-1:0]    in_user_node     = '0;
  logic [ELEM_IN_W-1:0] in_element_index = '0;
  val_t                 in_value         = '0;
  logic                 out_valid;
  val_t                 out_result_value;
  logic                 out_saturated;
  logic                 cfg_valid        = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [CFG_REG_W-1:0] cfg_data         = '0;

  pending_op_t request_q [$];
  sat_val_t    due_results [$];

  // Shadow of the block: latent vectors and the two registers
  int                   factor_mem [0:VLEN*NODES-1];
  logic [CFG_REG_W-1:0] cur_step   = STEP_SIZE_RESET;
  logic [CFG_REG_W-1:0] cur_lambda = REGULARIZATION_RESET;
  bit                   sat_hit;

  bit req_took = 1'b0;
  bit cfg_took = 1'b0;
  int gap_left = 0;
  int err_count = 0;
  int result_idx = 0;

  sgd_latent_factor_update_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_item_node     (in_item_node),
    .in_user_node     (in_user_node),
    .in_element_index (in_element_index),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_saturated    (out_saturated),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Clamp to the value width and note any clamp
  function automatic longint clamp_v(input longint v);
    if (v > VMAX) begin
      sat_hit = 1'b1;
      return VMAX;
    end
    if (v < VMIN) begin
      sat_hit = 1'b1;
      return VMIN;
    end
    return v;
  endfunction

  // Q8.24 product, rounded half up at the binary point
  function automatic longint qmul(input longint a, input longint b);
    longint p;
    p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
    return clamp_v(p >>> FRAC_BITS);
  endfunction

  // Apply one request to the shadow store and return its result
  function automatic sat_val_t predict_factor_step(input pending_op_t req);
    sat_val_t res;
    longint   old_i [VLEN];
    longint   old_u [VLEN];
    longint   rating, step_v, lam_v, acc, err, d_i, d_u, inc_i, inc_u;
    int       base_i, base_u, addr;
    sat_hit = 1'b0;
    res.val = '0;
    base_i = int'(req.item_node) * VLEN;
    base_u = int'(req.user_node) * VLEN;
    case (req.mode)
      MODE_LOAD, MODE_READ: begin
        if (req.elem < VLEN) begin
          addr = base_i + int'(req.elem);
          if (req.mode == MODE_LOAD) factor_mem[addr] = req.value;
          res.val = factor_mem[addr];
        end
      end
      MODE_UPDATE: begin
        rating = clamp_v(longint'(req.value));
        step_v = clamp_v(longint'(cur_step));
        lam_v  = clamp_v(longint'(cur_lambda));
        for (int k = 0; k < VLEN; k++) begin
          old_i[k] = factor_mem[base_i + k];
          old_u[k] = factor_mem[base_u + k];
        end
        // error against the dot product of the old vectors
        acc = 0;
        for (int k = 0; k < VLEN; k++) acc = clamp_v(acc + qmul(old_i[k], old_u[k]));
        err = clamp_v(rating - acc);
        // gradient step on both vectors from old values
        for (int k = 0; k < VLEN; k++) begin
          d_i   = clamp_v(qmul(err, old_u[k]) - qmul(lam_v, old_i[k]));
          d_u   = clamp_v(qmul(err, old_i[k]) - qmul(lam_v, old_u[k]));
          inc_i = qmul(step_v, d_i);
          inc_u = qmul(step_v, d_u);
          if (base_i == base_u) begin
            factor_mem[base_i + k] = int'(clamp_v(clamp_v(old_i[k] + inc_i) + inc_u));
          end else begin
            factor_mem[base_i + k] = int'(clamp_v(old_i[k] + inc_i));
            factor_mem[base_u + k] = int'(clamp_v(old_u[k] + inc_u));
          end
        end
        res.val = val_t'(err);
      end
      default: ;
    endcase
    res.sat = sat_hit;
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (err_count < 60) $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  function automatic val_t rand_fixed(input int span);
    return val_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic void queue_request(input logic [MODE_W-1:0] mode, input int item,
                                        input int user, input int elem, input val_t value);
    pending_op_t op;
    op = '0;
    op.mode      = mode;
    op.item_node = NODE_W'(item);
    op.user_node = NODE_W'(user);
    op.elem      = ELEM_IN_W'(elem);
    op.value     = value;
    request_q.push_back(op);
  endfunction

  function automatic void queue_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_REG_W-1:0] data);
    pending_op_t op;
    op = '0;
    op.is_cfg   = 1'b1;
    op.reg_idx  = idx;
    op.reg_data = data;
    request_q.push_back(op);
  endfunction

  // Fill a whole vector with small random values
  function automatic void queue_vector_load(input int node);
    for (int k = 0; k < VLEN; k++)
      queue_request(MODE_LOAD, node, $urandom_range(0, NODE_LAST), k, rand_fixed(ONE));
  endfunction

  initial begin : clk_gen
    forever #5 clk = ~clk;
  end

  initial begin : reset_seq
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Build the whole request list up front
  initial begin : stimulus_gen
    int   pool [3];
    int   pick, inode, unode, far_node, far_elem, fn, fe;
    bit   far_ok;
    val_t v;
    far_ok = 1'b0;
    far_node = 0;
    far_elem = 0;

    // directed: extremes, out-of-range element, unused mode, same-node update
    queue_vector_load(0);
    queue_vector_load(NODE_LAST);
    queue_request(MODE_LOAD, 0, NODE_LAST, 0, VAL_MAX);
    queue_request(MODE_LOAD, NODE_LAST, 0, VLEN - 1, VAL_MIN);
    queue_request(MODE_READ, 0, 0, 0, '0);
    queue_request(MODE_READ, NODE_LAST, NODE_LAST, VLEN - 1, '1);
    queue_request(MODE_LOAD, 7, 0, 31, VAL_MAX);
    queue_request(MODE_READ, NODE_LAST, 0, VLEN, '0);
    queue_request(MODE_NOP, NODE_LAST, NODE_LAST, 31, '1);
    queue_request(MODE_UPDATE, 0, NODE_LAST, 0, '0);
    queue_request(MODE_UPDATE, 0, 0, 31, VAL_MAX);
    queue_request(MODE_UPDATE, NODE_LAST, NODE_LAST, 0, VAL_MIN);
    queue_request(MODE_LOAD, 0, 0, 0, rand_fixed(ONE));
    queue_request(MODE_UPDATE, NODE_LAST, 0, 0, rand_fixed(4 * ONE));
    queue_request(MODE_READ, 0, 0, 0, '0);
    queue_request(MODE_READ, NODE_LAST, 0, VLEN - 1, '0);

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          queue_cfg(REG_STEP_SIZE, '0);
          queue_cfg(REG_REGULARIZATION, CFG_MAX);
          queue_cfg(REG_SPARE, '1);
        end
        1: begin
          queue_cfg(REG_STEP_SIZE, CFG_MAX);
          queue_cfg(REG_REGULARIZATION, '0);
        end
        2: begin
          queue_cfg(REG_STEP_SIZE, CFG_REG_W'($urandom_range(0, 2 * ONE)));
          queue_cfg(REG_REGULARIZATION, CFG_REG_W'($urandom_range(0, ONE)));
        end
        3: begin
          queue_cfg(REG_STEP_SIZE, CFG_MAX);
          queue_cfg(REG_REGULARIZATION, CFG_MAX);
        end
        default: begin
          queue_cfg(REG_STEP_SIZE, CFG_REG_W'($urandom_range(0, ONE / 4)));
          queue_cfg(REG_REGULARIZATION, CFG_REG_W'($urandom_range(0, ONE / 8)));
        end
      endcase

      // fresh working set of vectors
      for (int p = 0; p < 3; p++) begin
        pool[p] = $urandom_range(0, NODE_LAST);
        queue_vector_load(pool[p]);
      end

      for (int k = 0; k < MIX_ITEMS; k++) begin
        pick  = $urandom_range(0, 99);
        inode = pool[$urandom_range(0, 2)];
        if (pick < 40) begin
          unode = ($urandom_range(0, 4) == 0) ? inode : pool[$urandom_range(0, 2)];
          v = ($urandom_range(0, 9) == 0) ? val_t'($urandom) : rand_fixed(4 * ONE);
          queue_request(MODE_UPDATE, inode, unode, $urandom_range(0, 31), v);
        end else if (pick < 60) begin
          v = ($urandom_range(0, 9) == 0) ? val_t'($urandom) : rand_fixed(ONE);
          queue_request(MODE_LOAD, inode, $urandom_range(0, NODE_LAST),
                        $urandom_range(0, VLEN - 1), v);
        end else if (pick < 70) begin
          fn = $urandom_range(0, NODE_LAST);
          fe = $urandom_range(0, 31);
          queue_request(MODE_LOAD, fn, $urandom_range(0, NODE_LAST), fe, val_t'($urandom));
          if (fe < VLEN) begin
            far_ok   = 1'b1;
            far_node = fn;
            far_elem = fe;
          end
        end else if (pick < 90) begin
          if (far_ok && $urandom_range(0, 1) == 0)
            queue_request(MODE_READ, far_node, $urandom_range(0, NODE_LAST), far_elem,
                          val_t'($urandom));
          else
            queue_request(MODE_READ, inode, $urandom_range(0, NODE_LAST),
                          $urandom_range(0, 31), val_t'($urandom));
        end else begin
          queue_request(MODE_NOP, $urandom_range(0, NODE_LAST), $urandom_range(0, NODE_LAST),
                        $urandom_range(0, 31), val_t'($urandom));
        end
      end
    end
  end

  // Drive requests and register writes at the falling edge
  always @(negedge clk) begin : drive_proc
    logic        nx_start, nx_cfg;
    pending_op_t op;
    nx_start = start;
    nx_cfg   = cfg_valid;
    // drop the request just taken and maybe idle for a burst
    if (req_took) begin
      nx_start = 1'b0;
      req_took = 1'b0;
      if (request_q.size() > CALM_TAIL && $urandom_range(0, 2) == 0)
        gap_left = $urandom_range(1, 5);
    end
    if (cfg_took) begin
      nx_cfg   = 1'b0;
      cfg_took = 1'b0;
    end
    if (rst_n && !nx_start && !nx_cfg && request_q.size() > 0) begin
      op = request_q[0];
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
      end else if (op.is_cfg) begin
        // hold register writes until the block has drained
        if (due_results.size() == 0 && !busy) begin
          void'(request_q.pop_front());
          cfg_index <= op.reg_idx;
          cfg_data  <= op.reg_data;
          nx_cfg = 1'b1;
        end
      end else begin
        void'(request_q.pop_front());
        in_mode          <= op.mode;
        in_item_node     <= op.item_node;
        in_user_node     <= op.user_node;
        in_element_index <= op.elem;
        in_value         <= op.value;
        nx_start = 1'b1;
      end
    end
    start     <= nx_start;
    cfg_valid <= nx_cfg;
  end

  // Check results, track register writes and predict taken requests
  always @(posedge clk) begin : check_proc
    sat_val_t    want;
    pending_op_t seen;
    if (!rst_n) begin
      cur_step   = STEP_SIZE_RESET;
      cur_lambda = REGULARIZATION_RESET;
    end else begin
      if (out_valid) begin
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("result with nothing pending, value %h", out_result_value));
        end else begin
          want = due_results.pop_front();
          if (out_result_value !== want.val)
            flag_mismatch($sformatf("result %0d: result_value %h, want %h",
                                    result_idx, out_result_value, want.val));
          if (out_saturated !== want.sat)
            flag_mismatch($sformatf("result %0d: saturated %b, want %b",
                                    result_idx, out_saturated, want.sat));
        end
        result_idx++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STEP_SIZE:      cur_step = cfg_data;
          REG_REGULARIZATION: cur_lambda = cfg_data;
          default: ;
        endcase
        cfg_took = 1'b1;
      end
      if (start && !busy) begin
        seen = '0;
        seen.mode      = in_mode;
        seen.item_node = in_item_node;
        seen.user_node = in_user_node;
        seen.elem      = in_element_index;
        seen.value     = in_value;
        due_results.push_back(predict_factor_step(seen));
        req_took = 1'b1;
      end
    end
  end

  initial begin : finish_proc
    @(posedge rst_n);
    while (request_q.size() != 0 || start || cfg_valid || due_results.size() != 0)
      @(posedge clk);
    // let any stray result show up
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("sgd_latent_factor_update_core_tb: done, clean");
    end else begin
      $display("sgd_latent_factor_update_core_tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d results still pending", due_results.size());
    $display("sgd_latent_factor_update_core_tb: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
design/sgdlf_pkg.sv
design/sgdlf_store.sv
design/sgd_latent_factor_update_core.sv
test/sgd_latent_factor_update_core_tb.sv
